/* hw/rtl/stfla_pkg.sv */
package stfla_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int SLOT_W = 10;
	localparam int ID_W = 32;
	localparam int CMD_W = 2;
	localparam logic [ID_W-1:0] FIRST_ID_RST = 32'd100;

	typedef enum logic [CMD_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_FREE    = 3'd1,
		ST_BAD_INDEX  = 3'd2,
		ST_NOT_OCC    = 3'd3,
		ST_STACK_FULL = 3'd4
	} stat_t;

	// where the result slot and id come from
	typedef enum logic [1:0] {
		RS_ZERO = 2'd0,
		RS_ADD  = 2'd1,
		RS_SCAN = 2'd2
	} res_src_t;

	// one slot table word
	typedef struct packed {
		logic            occ;
		logic [ID_W-1:0] id;
	} slot_ent_t;

	// controller to datapath
	typedef struct packed {
		logic     cap;
		logic     stk_rd;
		logic     cand_rd;
		logic     idx_rd;
		logic     scan_rd;
		logic     scan_step;
		logic     add_wr;
		logic     rem_wr;
		logic     res_ld;
		res_src_t res_src;
		stat_t    res_code;
		logic     out_ld;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
		logic idx_bad;
		logic key_zero;
		logic cand_ok;
		logic slot_occ;
		logic stk_full;
		logic scan_end;
		logic scan_hit;
	} sts_t;

endpackage

/* hw/rtl/stfla_ctrl.sv */
module stfla_ctrl import stfla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] command,
	input  sts_t             sts,
	output cmd_t             cmd,
	output logic             in_stall
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_A_STK  = 9'b000000010,
		S_A_CAND = 9'b000000100,
		S_A_CHK  = 9'b000001000,
		S_R_RD   = 9'b000010000,
		S_R_CHK  = 9'b000100000,
		S_S_RD   = 9'b001000000,
		S_S_CMP  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_src  = RS_ZERO;
		cmd.res_code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					case (command)
						OP_ADD:    state_d = S_A_STK;
						OP_REMOVE: state_d = S_R_RD;
						OP_SEARCH: state_d = S_S_RD;
						default: begin
							// unused command answers all zero
							cmd.res_ld = 1'b1;
							state_d    = S_DONE;
						end
					endcase
				end
			end
			S_A_STK: begin
				cmd.stk_rd = 1'b1;
				state_d    = S_A_CAND;
			end
			S_A_CAND: begin
				cmd.cand_rd = 1'b1;
				state_d     = S_A_CHK;
			end
			S_A_CHK: begin
				cmd.res_ld = 1'b1;
				if (sts.cand_ok) begin
					cmd.add_wr  = 1'b1;
					cmd.res_src = RS_ADD;
				end else begin
					cmd.res_code = ST_NO_FREE;
				end
				state_d = S_DONE;
			end
			S_R_RD: begin
				if (sts.idx_bad) begin
					cmd.res_ld   = 1'b1;
					cmd.res_code = ST_BAD_INDEX;
					state_d      = S_DONE;
				end else begin
					cmd.idx_rd = 1'b1;
					state_d    = S_R_CHK;
				end
			end
			S_R_CHK: begin
				cmd.res_ld = 1'b1;
				if (!sts.slot_occ) begin
					cmd.res_code = ST_NOT_OCC;
				end else begin
					cmd.rem_wr   = 1'b1;
					cmd.res_code = sts.stk_full ? ST_STACK_FULL : ST_OK;
				end
				state_d = S_DONE;
			end
			S_S_RD: begin
				if (sts.key_zero || sts.scan_end) begin
					cmd.res_ld = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_S_CMP;
				end
			end
			S_S_CMP: begin
				if (sts.scan_hit) begin
					cmd.res_ld  = 1'b1;
					cmd.res_src = RS_SCAN;
					state_d     = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					state_d       = S_S_RD;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted beat left controller idle");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.add_wr && cmd.rem_wr))
		else $error("add and remove write in one cycle");

	a_done_loads_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> (state_q == S_IDLE))
		else $error("output load did not return to idle");
`endif

endmodule

/* hw/rtl/stfla_dp.sv */
module stfla_dp import stfla_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [ID_W-1:0]   search_key,
	input  logic              cfg_we,
	input  logic [ID_W-1:0]   cfg_wdata,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [SLOT_W-1:0] result_slot,
	output logic [ID_W-1:0]   assigned_id,
	output logic [2:0]        status
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
	localparam logic [IW-1:0] STK_MAX = IW'(SLOTS - 1);

	// storage
	slot_ent_t slot_mem [SLOTS];
	logic [IW-1:0] stk_mem [SLOTS];

	// item registers
	logic [SLOT_W-1:0] slot_index_q;
	logic [ID_W-1:0]   search_key_q;
	logic [IW-1:0]     idx;

	// allocator state
	logic [IW-1:0]   free_count_q;
	logic [CW-1:0]   bump_next_q;
	logic [ID_W-1:0] id_counter_q;

	// add path
	logic [IW-1:0] stk_rd_q;
	logic [IW-1:0] cand_q, cand;
	logic          cand_v_q, cand_v;
	logic          from_stk_q, from_stk;

	// search and slot read
	logic [CW-1:0] scan_q;
	slot_ent_t     slot_rd_q;
	logic          slot_rd_en;
	logic [IW-1:0] slot_rd_addr;

	// result and output
	logic [SLOT_W-1:0] res_slot_q, out_slot_q;
	logic [ID_W-1:0]   res_id_q, out_id_q;
	stat_t             res_st_q, out_st_q;
	logic              out_valid_q;

	assign idx = IW'(slot_index_q);

	assign from_stk = (free_count_q != '0);
	assign cand     = from_stk ? stk_rd_q : bump_next_q[IW-1:0];
	assign cand_v   = from_stk || (bump_next_q < SLOTS_C);

	// entries at or above the bump pointer were never written and read as free
	always_comb begin
		sts.out_busy = out_valid_q && out_stall;
		sts.idx_bad  = (slot_index_q == '0) || (32'(slot_index_q) >= 32'(SLOTS));
		sts.key_zero = (search_key_q == '0);
		sts.cand_ok  = cand_v_q && (cand_q != '0)
			&& !((CW'(cand_q) < bump_next_q) && slot_rd_q.occ);
		sts.slot_occ = slot_rd_q.occ && (CW'(idx) < bump_next_q);
		sts.stk_full = (free_count_q == STK_MAX);
		sts.scan_end = (scan_q >= bump_next_q);
		sts.scan_hit = slot_rd_q.occ && (slot_rd_q.id == search_key_q);
	end

	always_comb begin
		slot_rd_en   = cmd.cand_rd || cmd.idx_rd || cmd.scan_rd;
		slot_rd_addr = scan_q[IW-1:0];
		if (cmd.cand_rd) begin
			slot_rd_addr = cand;
		end else if (cmd.idx_rd) begin
			slot_rd_addr = idx;
		end
	end

	// slot table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			slot_mem[cand_q] <= '{occ: 1'b1, id: id_counter_q};
		end else if (cmd.rem_wr) begin
			slot_mem[idx] <= '{occ: 1'b0, id: slot_rd_q.id};
		end
		if (slot_rd_en) begin
			slot_rd_q <= slot_mem[slot_rd_addr];
		end
	end

	// free stack
	always_ff @(posedge clk) begin
		if (cmd.rem_wr && !sts.stk_full) begin
			stk_mem[free_count_q] <= idx;
		end
		if (cmd.stk_rd) begin
			stk_rd_q <= stk_mem[free_count_q - 1'b1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			slot_index_q <= slot_index;
			search_key_q <= search_key;
		end
		if (cmd.cand_rd) begin
			cand_q     <= cand;
			cand_v_q   <= cand_v;
			from_stk_q <= from_stk;
		end
		if (cmd.res_ld) begin
			case (cmd.res_src)
				RS_ADD: begin
					res_slot_q <= SLOT_W'(cand_q);
					res_id_q   <= id_counter_q;
				end
				RS_SCAN: begin
					res_slot_q <= SLOT_W'(scan_q[IW-1:0]);
					res_id_q   <= '0;
				end
				default: begin
					res_slot_q <= '0;
					res_id_q   <= '0;
				end
			endcase
			res_st_q <= cmd.res_code;
		end
		if (cmd.out_ld) begin
			out_slot_q <= res_slot_q;
			out_id_q   <= res_id_q;
			out_st_q   <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_count_q <= '0;
			bump_next_q  <= CW'(1);
			id_counter_q <= FIRST_ID_RST;
			scan_q       <= CW'(1);
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				id_counter_q <= cfg_wdata;
			end else if (cmd.add_wr) begin
				id_counter_q <= id_counter_q + 1'b1;
			end
			if (cmd.add_wr) begin
				if (from_stk_q) begin
					free_count_q <= free_count_q - 1'b1;
				end else begin
					bump_next_q <= bump_next_q + 1'b1;
				end
			end else if (cmd.rem_wr && !sts.stk_full) begin
				free_count_q <= free_count_q + 1'b1;
			end
			if (cmd.cap) begin
				scan_q <= CW'(1);
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_slot = out_slot_q;
	assign assigned_id = out_id_q;
	assign status      = out_st_q;

`ifndef SYNTHESIS
	a_free_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= STK_MAX)
		else $error("free stack count out of range");

	a_bump_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bump_next_q != '0) && (bump_next_q <= SLOTS_C))
		else $error("bump pointer out of range");

	a_add_target_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |-> (cand_v_q && (cand_q != '0)))
		else $error("add commits to an invalid slot");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");
`endif

endmodule

/* hw/rtl/slot_table_free_list_allocator_core.sv */
// channel  | direction | handshake            | payload
// in       | to block  | in_valid / in_stall   | command, slot_index, search_key
// out      | from block| out_valid / out_stall | result_slot, assigned_id, status
// cfg      | to block  | cfg_we                | cfg_wdata (first id)
//
// one beat in flight at a time; add steps through stack read, candidate read and check,
// remove through index read and check (a bad index ends at the read), search through a
// read and a compare per slot visited; search time is set by the single read port of the
// slot table, and the scan stops at the bump pointer since no slot above it was ever used
// a new input beat is taken while the previous result still waits on out_stall
// reset clears the counters and the output valid; the slot table and the free
// stack need no clearing pass since the bump pointer and stack count bound them
module slot_table_free_list_allocator_core import stfla_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic [ID_W-1:0]   search_key,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] result_slot,
	output logic [ID_W-1:0]   assigned_id,
	output logic [2:0]        status,
	// first id register, also reloads the id counter
	input  logic              cfg_we,
	input  logic [ID_W-1:0]   cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: decodes the command at accept and steps through memory cycles
	stfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// slot table, free stack, counters and the output register
	stfla_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.slot_index  (slot_index),
		.search_key  (search_key),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.result_slot (result_slot),
		.assigned_id (assigned_id),
		.status      (status)
	);

endmodule

/* test/slot_shadow_pkg.sv */
`timescale 1ns / 100ps
package slot_shadow_pkg;
	import stfla_pkg::*;

	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		stat_t             st;
	} answer_t;

	// shadow copy of the slot table and the answers it still owes
	class slot_table_shadow;
		bit              occ[SLOTS_DEF];
		bit [ID_W-1:0]   ids[SLOTS_DEF];
		bit [SLOT_W-1:0] freed[$];
		int unsigned     live[$];
		int unsigned     bump;
		bit [ID_W-1:0]   next_id;
		answer_t         awaited[$];
		int              mismatches;
		int              n_cmd[4];
		int              n_stat[8];
		int              n_hits;
		int              n_loads;

		function new();
			bump = 1;
			next_id = FIRST_ID_RST;
		endfunction

		function void load_first_id(logic [ID_W-1:0] v);
			next_id = v;
			n_loads++;
		endfunction

		function int unsigned pick_live();
			if (live.size() == 0)
				return 0;
			return live[$urandom_range(0, live.size() - 1)];
		endfunction

		function void drop_live(int unsigned s);
			foreach (live[i]) begin
				if (live[i] == s) begin
					live.delete(i);
					return;
				end
			end
		endfunction

		// accepted input beat: update the table and queue the answer it owes
		function void note_command(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] idx,
				logic [ID_W-1:0] key);
			answer_t     a;
			int unsigned cand;
			bit          from_stack;
			a = '0;
			cand = 0;
			from_stack = 0;
			case (cmd)
				OP_ADD: begin
					if (freed.size() > 0) begin
						cand = freed[$];
						from_stack = 1;
					end else if (bump < SLOTS_DEF) begin
						cand = bump;
					end
					if (cand == 0 || occ[cand]) begin
						a.st = ST_NO_FREE;
					end else begin
						occ[cand] = 1;
						ids[cand] = next_id;
						live.push_back(cand);
						a.slot = SLOT_W'(cand);
						a.id = next_id;
						next_id++;
						if (from_stack)
							void'(freed.pop_back());
						else
							bump++;
					end
				end
				OP_REMOVE: begin
					if (idx == 0 || idx >= SLOTS_DEF) begin
						a.st = ST_BAD_INDEX;
					end else if (!occ[idx]) begin
						a.st = ST_NOT_OCC;
					end else begin
						occ[idx] = 0;
						drop_live(idx);
						if (freed.size() < SLOTS_DEF - 1)
							freed.push_back(idx);
						else
							a.st = ST_STACK_FULL;
					end
				end
				OP_SEARCH: begin
					if (key != 0) begin
						for (int i = 1; i < SLOTS_DEF; i++) begin
							if (occ[i] && ids[i] == key) begin
								a.slot = SLOT_W'(i);
								n_hits++;
								break;
							end
						end
					end
				end
				default: begin
				end
			endcase
			n_cmd[cmd]++;
			n_stat[a.st]++;
			awaited.push_back(a);
		endfunction

		function void check_result(logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
				logic [2:0] st);
			answer_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result beat with none awaited: slot %0d id %0h status %0d",
						$time, slot, id, st);
				return;
			end
			e = awaited.pop_front();
			if (slot !== e.slot) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result_slot expected %0d actual %0d", $time, e.slot, slot);
			end
			if (id !== e.id) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: assigned_id expected %0h actual %0h", $time, e.id, id);
			end
			if (st !== e.st) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: status expected %0d actual %0d", $time, e.st, st);
			end
		endfunction
	endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 100ps
module tb;
	import stfla_pkg::*;
	import slot_shadow_pkg::*;

	// command code the block has no operation for
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	// worst search walks every slot, plus margin
	localparam int END_CYCLES = 2 * SLOTS_DEF + 16;
	localparam int LIMIT_CYCLES = 10_000_000;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 85;

	typedef enum int {
		CHURN,
		GROW,
		SHRINK
	} churn_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  command = '0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic [ID_W-1:0]   search_key = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SLOT_W-1:0] result_slot;
	logic [ID_W-1:0]   assigned_id;
	logic [2:0]        status;
	logic              cfg_we = 1'b0;
	logic [ID_W-1:0]   cfg_wdata = '0;

	slot_table_shadow shadow;
	bit               gap_on;
	bit               stall_on;
	int               stall_left;
	int               cycles;

	slot_table_free_list_allocator_core #(
		.SLOTS(SLOTS_DEF)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.slot_index  (slot_index),
		.search_key  (search_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_slot (result_slot),
		.assigned_id (assigned_id),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit, several times above the slowest clean run (every beat a full
	// table search behind the longest gap and stall)
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timed out after %0d cycles, %0d answers still awaited",
				cycles, shadow.awaited.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// both channels are watched at the rising edge, with the values held since the
	// falling edge; a result beat always belongs to an older input beat, so the
	// order of the two calls does not matter
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall === 1'b0)
			shadow.note_command(command, slot_index, search_key);
		if (arst_n && out_valid === 1'b1 && !out_stall)
			shadow.check_result(result_slot, assigned_id, status);
	end

	// receiver back-pressure in random bursts while stall_on is set
	always @(negedge clk) begin
		if (stall_on && stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_on && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// present one beat at the falling edge and hold it until taken;
	// returns at the falling edge after the accepting one
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [ID_W-1:0] k);
		if (gap_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		slot_index <= s;
		search_key <= k;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// hold off the sender until every awaited answer is back
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (shadow.awaited.size() != 0);
	endtask

	// first id may only change while the block is idle
	task automatic write_first_id(input logic [ID_W-1:0] v);
		settle();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow.load_first_id(v);
	endtask

	// one random beat, weighted by the phase; removes and searches mostly aim at
	// slots that are in use so the table sees real traffic, the rest is noise
	task automatic random_beat(input churn_t mode);
		int                pick;
		int                aim;
		logic [CMD_W-1:0]  c;
		logic [SLOT_W-1:0] s;
		logic [ID_W-1:0]   k;
		pick = $urandom_range(0, 99);
		aim = $urandom_range(0, 9);
		s = SLOT_W'($urandom);
		k = $urandom;
		case (mode)
			GROW:    c = pick < 75 ? OP_ADD : pick < 85 ? OP_REMOVE :
				pick < 95 ? OP_SEARCH : CMD_SPARE;
			SHRINK:  c = pick < 12 ? OP_ADD : pick < 80 ? OP_REMOVE :
				pick < 95 ? OP_SEARCH : CMD_SPARE;
			default: c = pick < 36 ? OP_ADD : pick < 66 ? OP_REMOVE :
				pick < 93 ? OP_SEARCH : CMD_SPARE;
		endcase
		if (c == OP_REMOVE) begin
			if (aim < 8 && shadow.live.size() > 0)
				s = SLOT_W'(shadow.pick_live());
			else if (aim == 8)
				s = '0;
		end else if (c == OP_SEARCH) begin
			if (aim < 6 && shadow.live.size() > 0)
				k = shadow.ids[shadow.pick_live()];
			else if (aim == 6)
				k = '0;
			else if (aim == 7)
				k = shadow.next_id - 1;
		end
		send_beat(c, s, k);
	endtask

	initial begin
		shadow = new();
		gap_on = 1;
		stall_on = 1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, range edges, ignored fields at all ones
		send_beat(OP_SEARCH, '0, '0);
		send_beat(OP_SEARCH, '1, '1);
		send_beat(OP_REMOVE, '0, '1);
		send_beat(OP_REMOVE, '1, '0);
		send_beat(CMD_SPARE, '1, '1);
		// first adds come off the bump pointer with ids from the reset value
		send_beat(OP_ADD, '1, '1);
		send_beat(OP_ADD, '0, '0);
		send_beat(OP_ADD, '0, '0);
		send_beat(OP_SEARCH, '0, FIRST_ID_RST + 1);
		send_beat(OP_REMOVE, 10'd2, '0);
		send_beat(OP_REMOVE, 10'd2, '0);
		// next add must pop the freed slot
		send_beat(OP_ADD, '0, '0);
		send_beat(OP_SEARCH, '0, FIRST_ID_RST + 3);
		send_beat(OP_SEARCH, '1, FIRST_ID_RST);
		send_beat(CMD_SPARE, '0, '0);

		// id counter wraps through zero; a zero id can never be found
		write_first_id(32'hFFFF_FFFE);
		send_beat(OP_ADD, '0, '0);
		send_beat(OP_ADD, '0, '0);
		send_beat(OP_ADD, '0, '0);
		send_beat(OP_SEARCH, '0, '0);
		send_beat(OP_SEARCH, '0, 32'hFFFF_FFFF);
		send_beat(OP_REMOVE, 10'd1, '0);
		write_first_id('0);
		send_beat(OP_ADD, '0, '0);
		send_beat(OP_SEARCH, '0, 32'h0000_0001);

		// random phases, each behind a first id load or at least a full drain
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: write_first_id($urandom);
				1: write_first_id(p == 1 ? 32'hFFFF_FFFF : 32'hFFFF_FFFF - $urandom_range(1, 3));
				2: write_first_id(p == 2 ? 32'h0 : $urandom_range(1, 2));
				default: settle();
			endcase
			gap_on = (p % 3 != 2);
			stall_on = gap_on;
			repeat (PHASE_BEATS) begin
				case (p % 4)
					0: random_beat(GROW);
					2: random_beat(SHRINK);
					default: random_beat(CHURN);
				endcase
			end
		end

		// last part at full rate: a burst of adds, searches for live ids, then
		// removes so the stack deepens and later adds pop it
		gap_on = 0;
		stall_on = 0;
		write_first_id($urandom);
		repeat (40) send_beat(OP_ADD, SLOT_W'($urandom), $urandom);
		repeat (4) send_beat(OP_SEARCH, SLOT_W'($urandom), shadow.ids[shadow.pick_live()]);
		send_beat(OP_SEARCH, SLOT_W'($urandom), $urandom);
		repeat (20) send_beat(OP_REMOVE, SLOT_W'(shadow.pick_live()), $urandom);
		send_beat(OP_REMOVE, SLOT_W'($urandom_range(1, SLOTS_DEF - 1)), $urandom);
		repeat (40) begin
			if ($urandom_range(0, 3) == 0)
				send_beat(OP_SEARCH, SLOT_W'($urandom), shadow.ids[shadow.pick_live()]);
			else
				send_beat(OP_ADD, SLOT_W'($urandom), $urandom);
		end

		settle();
		repeat (END_CYCLES) @(negedge clk);

		$display("run covered %0d adds, %0d removes, %0d searches (%0d found), %0d spare commands",
			shadow.n_cmd[OP_ADD], shadow.n_cmd[OP_REMOVE], shadow.n_cmd[OP_SEARCH],
			shadow.n_hits, shadow.n_cmd[CMD_SPARE]);
		$display("answers: ok %0d, no free %0d, bad index %0d, not occupied %0d; %0d first id loads",
			shadow.n_stat[ST_OK], shadow.n_stat[ST_NO_FREE], shadow.n_stat[ST_BAD_INDEX],
			shadow.n_stat[ST_NOT_OCC], shadow.n_loads);
		if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
